>>> sv/beo_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// beo_pkg
// Shared constants for the back-EMF rotor angle observer: register map,
// gain widths and the CORDIC arctangent table.
// ============================================================================
package beo_pkg;

    // configuration port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // register index, taken from paddr[2]
    localparam logic REG_DECAY_GAIN = 1'b0;
    localparam logic REG_INPUT_GAIN = 1'b1;

    // gain register widths
    localparam int DECAY_W = 15;
    localparam int GAIN_W  = 16;

    // output angle, 32768 equals pi
    localparam int ANGLE_W   = 16;
    localparam int ANGLE_MAX = 16384;

    // angle accumulator width, pi equals 2^31
    localparam int Z_W = 34;

    // atan(2^-i) with pi equals 2^31
    localparam int ATAN_DEPTH = 24;
    localparam logic [31:0] ATAN_TAB [ATAN_DEPTH] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81
    };

endpackage

>>> sv/beo_lane.sv
`timescale 1ns / 1ps
// ============================================================================
// beo_lane
// One axis of the observer: predicts the current from the previous sample,
// then forms the new back-EMF as prediction minus measurement. Keeps the
// previous current, voltage and back-EMF of its axis.
// ============================================================================
module beo_lane
    import beo_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 16
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [DECAY_W-1:0]             decay_gain,
    input  logic [GAIN_W-1:0]              input_gain,
    input  logic signed [SAMPLE_WIDTH-1:0] current,
    input  logic signed [SAMPLE_WIDTH-1:0] volt,
    output logic signed [SAMPLE_WIDTH-1:0] emf,
    output logic                           emf_valid
);

    localparam int SW    = SAMPLE_WIDTH;
    localparam int D_W   = SW + 1;
    localparam int PF_W  = SW + DECAY_W + 1;
    localparam int PG_W  = D_W + GAIN_W + 1;
    localparam int ACC_W = SW + 22;

    localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(16384);
    localparam logic signed [ACC_W-1:0] ACC_MAX  = ACC_W'({1'b0, {(SW-1){1'b1}}});
    localparam logic signed [ACC_W-1:0] ACC_MIN  = ~ACC_MAX;
    localparam logic signed [D_W-1:0]   D_MAX    = D_W'({1'b0, {(SW-1){1'b1}}});
    localparam logic signed [D_W-1:0]   D_MIN    = ~D_MAX;

    logic signed [SW-1:0]    prev_cur_reg;
    logic signed [SW-1:0]    prev_volt_reg;
    logic signed [SW-1:0]    prev_emf_reg;
    logic signed [SW-1:0]    meas_reg;
    logic signed [PF_W-1:0]  prod_f_reg;
    logic signed [PG_W-1:0]  prod_g_reg;
    logic signed [SW-1:0]    pred_reg;
    logic                    s1_reg;
    logic                    s2_reg;
    logic                    s3_reg;

    logic signed [DECAY_W:0] kf_s;
    logic signed [GAIN_W:0]  kg_s;
    logic signed [D_W-1:0]   drive;
    logic signed [PF_W-1:0]  prod_f_next;
    logic signed [PG_W-1:0]  prod_g_next;
    logic signed [ACC_W-1:0] acc;
    logic signed [ACC_W-1:0] acc_shr;
    logic signed [SW-1:0]    pred_next;
    logic signed [D_W-1:0]   diff;
    logic signed [SW-1:0]    emf_next;

    // stage 1: the two gain products
    always_comb
    begin
        kf_s        = signed'({1'b0, decay_gain});
        kg_s        = signed'({1'b0, input_gain});
        drive       = D_W'(prev_volt_reg) - D_W'(prev_emf_reg);
        prod_f_next = PF_W'(kf_s) * PF_W'(prev_cur_reg);
        prod_g_next = PG_W'(kg_s) * PG_W'(drive);
    end

    // stage 2: sum, round to nearest and saturate the prediction
    always_comb
    begin
        acc     = ACC_W'(prod_f_reg) + (ACC_W'(prod_g_reg) <<< 3) + RND_HALF;
        acc_shr = acc >>> 15;
        if (acc_shr > ACC_MAX)
        begin
            pred_next = ACC_MAX[SW-1:0];
        end
        else if (acc_shr < ACC_MIN)
        begin
            pred_next = ACC_MIN[SW-1:0];
        end
        else
        begin
            pred_next = acc_shr[SW-1:0];
        end
    end

    // stage 3: back-EMF is prediction minus measurement, saturated
    always_comb
    begin
        diff = D_W'(pred_reg) - D_W'(meas_reg);
        if (diff > D_MAX)
        begin
            emf_next = D_MAX[SW-1:0];
        end
        else if (diff < D_MIN)
        begin
            emf_next = D_MIN[SW-1:0];
        end
        else
        begin
            emf_next = diff[SW-1:0];
        end
    end

    // axis state and stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_cur_reg  <= '0;
            prev_volt_reg <= '0;
            prev_emf_reg  <= '0;
            s1_reg        <= 1'b0;
            s2_reg        <= 1'b0;
            s3_reg        <= 1'b0;
        end
        else
        begin
            s1_reg <= start;
            s2_reg <= s1_reg;
            s3_reg <= s2_reg;
            if (start)
            begin
                prev_cur_reg  <= current;
                prev_volt_reg <= volt;
            end
            if (s2_reg)
            begin
                prev_emf_reg <= emf_next;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            prod_f_reg <= prod_f_next;
            prod_g_reg <= prod_g_next;
            meas_reg   <= current;
        end
        if (s1_reg)
        begin
            pred_reg <= pred_next;
        end
    end

    assign emf       = prev_emf_reg;
    assign emf_valid = s3_reg;

endmodule

>>> sv/beo_cordic.sv
`timescale 1ns / 1ps
// ============================================================================
// beo_cordic
// Merging stage: turns the alpha and beta back-EMF into the rotor angle
// atan(-emf_alpha / emf_beta) by CORDIC vectoring, one iteration per cycle.
// ============================================================================
module beo_cordic
    import beo_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 16,
    parameter int CORDIC_STEPS = 16
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic signed [SAMPLE_WIDTH-1:0] emf_alpha,
    input  logic signed [SAMPLE_WIDTH-1:0] emf_beta,
    output logic                           done,
    output logic signed [ANGLE_W-1:0]      angle
);

    localparam int SW    = SAMPLE_WIDTH;
    localparam int XY_W  = SW + 4;
    localparam int CNT_W = $clog2(CORDIC_STEPS);
    localparam int TAB_W = $clog2(ATAN_DEPTH);

    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(CORDIC_STEPS - 1);

    localparam logic signed [Z_W-1:0] Z_HALF = Z_W'(32768);
    localparam logic signed [Z_W-1:0] Z_LIM  = Z_W'(ANGLE_MAX);
    localparam logic signed [Z_W-1:0] Z_NLIM = -Z_LIM;

    localparam logic signed [ANGLE_W-1:0] ANG_POS = ANGLE_W'(ANGLE_MAX);
    localparam logic signed [ANGLE_W-1:0] ANG_NEG = -ANG_POS;

    // sequencer codes
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;

    logic [1:0]                 state_reg;
    logic [CNT_W-1:0]           cnt_reg;
    logic                       done_reg;
    logic signed [XY_W-1:0]     x_reg;
    logic signed [XY_W-1:0]     y_reg;
    logic signed [Z_W-1:0]      z_reg;
    logic signed [ANGLE_W-1:0]  angle_reg;

    logic signed [XY_W-1:0]     mag_b;
    logic signed [XY_W-1:0]     y_init;
    logic signed [XY_W-1:0]     dx;
    logic signed [XY_W-1:0]     dy;
    logic signed [XY_W-1:0]     x_next;
    logic signed [XY_W-1:0]     y_next;
    logic signed [Z_W-1:0]      step_ang;
    logic signed [Z_W-1:0]      z_next;
    logic signed [Z_W-1:0]      z_rnd;
    logic signed [ANGLE_W-1:0]  special;
    logic signed [ANGLE_W-1:0]  final_ang;

    // starting vector: beta magnitude on x, alpha folded on y, both times 4
    always_comb
    begin
        if (emf_beta < 0)
        begin
            mag_b  = -XY_W'(emf_beta);
            y_init = XY_W'(emf_alpha);
        end
        else
        begin
            mag_b  = XY_W'(emf_beta);
            y_init = -XY_W'(emf_alpha);
        end
    end

    // zero beta gives plus or minus pi/2, or zero when alpha is zero too
    always_comb
    begin
        if (emf_alpha < 0)
        begin
            special = ANG_POS;
        end
        else if (emf_alpha > 0)
        begin
            special = ANG_NEG;
        end
        else
        begin
            special = '0;
        end
    end

    // one vectoring iteration with floor shifts
    always_comb
    begin
        dx       = y_reg >>> cnt_reg;
        dy       = x_reg >>> cnt_reg;
        step_ang = Z_W'(ATAN_TAB[TAB_W'(cnt_reg)]);
        if (y_reg >= 0)
        begin
            x_next = x_reg + dx;
            y_next = y_reg - dy;
            z_next = z_reg + step_ang;
        end
        else
        begin
            x_next = x_reg - dx;
            y_next = y_reg + dy;
            z_next = z_reg - step_ang;
        end
    end

    // round the accumulated angle and clamp to plus or minus pi/2
    always_comb
    begin
        z_rnd = (z_reg + Z_HALF) >>> 16;
        if (z_rnd > Z_LIM)
        begin
            final_ang = ANG_POS;
        end
        else if (z_rnd < Z_NLIM)
        begin
            final_ang = ANG_NEG;
        end
        else
        begin
            final_ang = z_rnd[ANGLE_W-1:0];
        end
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    cnt_reg <= '0;
                    if (start)
                    begin
                        if (emf_beta == 0)
                        begin
                            done_reg <= 1'b1;
                        end
                        else
                        begin
                            state_reg <= ST_RUN;
                        end
                    end
                end
                ST_RUN:
                begin
                    if (cnt_reg == CNT_LAST)
                    begin
                        state_reg <= ST_FIN;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                ST_FIN:
                begin
                    done_reg  <= 1'b1;
                    state_reg <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // vector and angle registers
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && start)
        begin
            x_reg     <= mag_b <<< 2;
            y_reg     <= y_init <<< 2;
            z_reg     <= '0;
            angle_reg <= special;
        end
        else if (state_reg == ST_RUN)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
        else if (state_reg == ST_FIN)
        begin
            angle_reg <= final_ang;
        end
    end

    assign done  = done_reg;
    assign angle = angle_reg;

endmodule

>>> sv/back_emf_rotor_angle_observer_unit.sv
`timescale 1ns / 1ps
// ============================================================================
// back_emf_rotor_angle_observer_unit
// Back-EMF observer with CORDIC rotor angle estimate, APB register port.
// ============================================================================
// Each input transaction is one alpha/beta sample of currents and voltages.
// Two axis lanes predict the currents from the previous sample and form the
// back-EMF through registered product, prediction and back-EMF stages; a
// shared CORDIC unit then loads its vector, runs CORDIC_STEPS iterations
// and a rounding step (a zero beta back-EMF gives the angle directly), and
// the angle is moved to the output register once that register is free.
// The next sample is accepted only after that move, so one item is in
// flight at a time, and the next sample is taken while a result waits on
// the output. Gains are written over APB at 0x0 (decay_gain) and 0x4
// (input_gain) and should only change while the block is idle.
module back_emf_rotor_angle_observer_unit
    import beo_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 16,
    parameter int CORDIC_STEPS = 16
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    // apb configuration
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [APB_ADDR_W-1:0]          paddr,
    input  logic [APB_DATA_W-1:0]          pwdata,
    output logic [APB_DATA_W-1:0]          prdata,
    output logic                           pready,
    // sample input
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic signed [SAMPLE_WIDTH-1:0] current_alpha,
    input  logic signed [SAMPLE_WIDTH-1:0] current_beta,
    input  logic signed [SAMPLE_WIDTH-1:0] volt_alpha,
    input  logic signed [SAMPLE_WIDTH-1:0] volt_beta,
    // angle output
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic signed [ANGLE_W-1:0]      rotor_angle
);

    // control codes
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_BUSY = 2'd1;
    localparam logic [1:0] ST_HOLD = 2'd2;

    logic [DECAY_W-1:0]             decay_gain_reg;
    logic [GAIN_W-1:0]              input_gain_reg;
    logic [1:0]                     state_reg;
    logic                           out_valid_reg;
    logic signed [ANGLE_W-1:0]      rotor_angle_reg;

    logic                           apb_write;
    logic                           accept;
    logic                           load_out;
    logic signed [SAMPLE_WIDTH-1:0] emf_a;
    logic signed [SAMPLE_WIDTH-1:0] emf_b;
    logic                           emf_a_valid;
    logic                           emf_b_valid;
    logic                           cordic_done;
    logic signed [ANGLE_W-1:0]      cordic_angle;

    // register port
    assign pready    = 1'b1;
    assign apb_write = psel & penable & pwrite & pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            decay_gain_reg <= '0;
            input_gain_reg <= '0;
        end
        else if (apb_write)
        begin
            unique case (paddr[2])
                REG_DECAY_GAIN: decay_gain_reg <= pwdata[DECAY_W-1:0];
                REG_INPUT_GAIN: input_gain_reg <= pwdata[GAIN_W-1:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_DECAY_GAIN: prdata = APB_DATA_W'(decay_gain_reg);
            REG_INPUT_GAIN: prdata = APB_DATA_W'(input_gain_reg);
            default:        prdata = '0;
        endcase
    end

    // handshakes
    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid & in_ready;
    assign load_out = (state_reg == ST_HOLD) & (~out_valid_reg | out_ready);

    // alpha and beta lanes
    beo_lane #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_lane_alpha (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (accept),
        .decay_gain (decay_gain_reg),
        .input_gain (input_gain_reg),
        .current    (current_alpha),
        .volt       (volt_alpha),
        .emf        (emf_a),
        .emf_valid  (emf_a_valid)
    );

    beo_lane #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_lane_beta (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (accept),
        .decay_gain (decay_gain_reg),
        .input_gain (input_gain_reg),
        .current    (current_beta),
        .volt       (volt_beta),
        .emf        (emf_b),
        .emf_valid  (emf_b_valid)
    );

    // angle from the two back-EMF terms
    beo_cordic #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (emf_a_valid & emf_b_valid),
        .emf_alpha (emf_a),
        .emf_beta  (emf_b),
        .done      (cordic_done),
        .angle     (cordic_angle)
    );

    // transaction control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= ST_BUSY;
                    end
                end
                ST_BUSY:
                begin
                    if (cordic_done)
                    begin
                        state_reg <= ST_HOLD;
                    end
                end
                ST_HOLD:
                begin
                    if (load_out)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase

            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            rotor_angle_reg <= cordic_angle;
        end
    end

    assign out_valid   = out_valid_reg;
    assign rotor_angle = rotor_angle_reg;

endmodule

>>> test/beo_angle_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// beo_angle_checker
// Watches the register, sample and angle ports of the back-EMF observer,
// keeps its own copy of the observer state and gains, works out the rotor
// angle for every accepted sample and compares it with the delivered one.
// ============================================================================
module beo_angle_checker
    import beo_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 16,
    parameter int CORDIC_STEPS = 16
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [APB_ADDR_W-1:0]          paddr,
    input  logic [APB_DATA_W-1:0]          pwdata,
    input  logic [APB_DATA_W-1:0]          prdata,
    input  logic                           pready,
    input  logic                           in_valid,
    input  logic                           in_ready,
    input  logic signed [SAMPLE_WIDTH-1:0] current_alpha,
    input  logic signed [SAMPLE_WIDTH-1:0] current_beta,
    input  logic signed [SAMPLE_WIDTH-1:0] volt_alpha,
    input  logic signed [SAMPLE_WIDTH-1:0] volt_beta,
    input  logic                           out_valid,
    input  logic                           out_ready,
    input  logic signed [ANGLE_W-1:0]      rotor_angle,
    output int                             mismatch_count,
    output int                             angles_pending
);

    typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
    typedef logic signed [ANGLE_W-1:0]      angle_t;

    localparam longint SAMPLE_MAX = (longint'(1) <<< (SAMPLE_WIDTH - 1)) - 1;
    localparam longint SAMPLE_MIN = -(longint'(1) <<< (SAMPLE_WIDTH - 1));
    localparam int     ARCTAN_DEPTH = 24;

    // arctangent of 2^-i, pi is 2^31
    localparam longint ARCTAN_STEP [ARCTAN_DEPTH] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838,  5340245,   2670163,   1335087,  667544,   333772,
        166886,    83443,     41722,     20861,    10430,    5215,
        2608,      1304,      652,       326,      163,      81
    };

    // gains and observer history
    logic [DECAY_W-1:0]    decay_gain;
    logic [GAIN_W-1:0]     input_gain;
    sample_t               last_cur_a, last_cur_b;
    sample_t               last_volt_a, last_volt_b;
    sample_t               last_emf_a, last_emf_b;

    angle_t                pending_angles [$];
    sample_t               pred_a, pred_b, emf_a, emf_b;
    angle_t                angle_due;
    logic [APB_DATA_W-1:0] reg_word;
    int                    errors;

    function automatic sample_t saturate(input longint v);
        if (v > SAMPLE_MAX)
            return sample_t'(SAMPLE_MAX);
        if (v < SAMPLE_MIN)
            return sample_t'(SAMPLE_MIN);
        return sample_t'(v);
    endfunction

    // current one sample ahead: kf * i + kg * (v - e), rounded half up
    function automatic sample_t predict_current(input sample_t cur, input sample_t volt,
                                                input sample_t emf);
        longint acc;
        acc = longint'(decay_gain) * longint'(cur)
            + longint'(input_gain) * (longint'(volt) - longint'(emf)) * 8;
        return saturate((acc + 16384) >>> 15);
    endfunction

    // atan(-ea / eb) by cordic vectoring, clamped to +-pi/2
    function automatic angle_t emf_angle(input sample_t ea, input sample_t eb);
        longint a, b, x, y, z, dx, dy;
        a = ea;
        b = eb;
        z = 0;
        if (b == 0) begin
            if (a < 0)
                return angle_t'(ANGLE_MAX);
            if (a > 0)
                return angle_t'(-ANGLE_MAX);
            return '0;
        end
        x = (b < 0 ? -b : b) * 4;
        y = (b < 0 ? a : -a) * 4;
        for (int i = 0; i < CORDIC_STEPS && i < ARCTAN_DEPTH; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0) begin
                x = x + dx;
                y = y - dy;
                z = z + ARCTAN_STEP[i];
            end else begin
                x = x - dx;
                y = y + dy;
                z = z - ARCTAN_STEP[i];
            end
        end
        z = (z + 32768) >>> 16;
        if (z > ANGLE_MAX)
            z = ANGLE_MAX;
        if (z < -ANGLE_MAX)
            z = -ANGLE_MAX;
        return angle_t'(z);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            decay_gain  = '0;
            input_gain  = '0;
            last_cur_a  = '0;
            last_cur_b  = '0;
            last_volt_a = '0;
            last_volt_b = '0;
            last_emf_a  = '0;
            last_emf_b  = '0;
            pending_angles.delete();
            errors = 0;
            mismatch_count <= 0;
            angles_pending <= 0;
        end else begin
            // register access
            if (psel && penable && pready) begin
                if (pwrite) begin
                    if (paddr[2] == REG_DECAY_GAIN)
                        decay_gain = pwdata[DECAY_W-1:0];
                    else
                        input_gain = pwdata[GAIN_W-1:0];
                end else begin
                    reg_word = (paddr[2] == REG_DECAY_GAIN) ? APB_DATA_W'(decay_gain)
                                                             : APB_DATA_W'(input_gain);
                    if (prdata !== reg_word) begin
                        $error("prdata: expected %0h, actual %0h", reg_word, prdata);
                        errors++;
                    end
                end
            end

            // angle transaction against the oldest prediction
            if (out_valid && out_ready) begin
                if (pending_angles.size() == 0) begin
                    $error("rotor_angle: expected none, actual %0d", rotor_angle);
                    errors++;
                end else begin
                    angle_due = pending_angles.pop_front();
                    if (rotor_angle !== angle_due) begin
                        $error("rotor_angle: expected %0d, actual %0d", angle_due,
                               rotor_angle);
                        errors++;
                    end
                end
            end

            // sample transaction: observer step
            if (in_valid && in_ready) begin
                pred_a = predict_current(last_cur_a, last_volt_a, last_emf_a);
                pred_b = predict_current(last_cur_b, last_volt_b, last_emf_b);
                emf_a  = saturate(longint'(pred_a) - longint'(current_alpha));
                emf_b  = saturate(longint'(pred_b) - longint'(current_beta));
                pending_angles.push_back(emf_angle(emf_a, emf_b));
                last_cur_a  = current_alpha;
                last_cur_b  = current_beta;
                last_volt_a = volt_alpha;
                last_volt_b = volt_beta;
                last_emf_a  = emf_a;
                last_emf_b  = emf_b;
            end

            mismatch_count <= errors;
            angles_pending <= pending_angles.size();
        end
    end

endmodule

>>> test/tb_top.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_top
// Drives samples and gain settings into the back-EMF rotor angle observer
// under random idling on both channels, with a long output stall and a
// drain pause, and reports the verdict from the attached angle checker.
// ============================================================================
module tb_top;
    import beo_pkg::*;

    localparam int SAMPLE_W      = 16;
    localparam int STEPS         = 16;
    localparam int SETTLE_CYCLES = STEPS + 10;
    localparam int HOLD_CYCLES   = 300;
    localparam int QUIET_LIMIT   = 5000;

    logic                       clk;
    logic                       rst_n;
    logic                       psel;
    logic                       penable;
    logic                       pwrite;
    logic [APB_ADDR_W-1:0]      paddr;
    logic [APB_DATA_W-1:0]      pwdata;
    logic [APB_DATA_W-1:0]      prdata;
    logic                       pready;
    logic                       in_valid;
    logic                       in_ready;
    logic signed [SAMPLE_W-1:0] current_alpha;
    logic signed [SAMPLE_W-1:0] current_beta;
    logic signed [SAMPLE_W-1:0] volt_alpha;
    logic signed [SAMPLE_W-1:0] volt_beta;
    logic                       out_valid;
    logic                       out_ready;
    logic signed [ANGLE_W-1:0]  rotor_angle;

    int mismatch_count;
    int angles_pending;
    int quiet_cycles;
    bit calm     = 1'b0;
    bit hold_req = 1'b0;

    back_emf_rotor_angle_observer_unit #(
        .SAMPLE_WIDTH (SAMPLE_W),
        .CORDIC_STEPS (STEPS)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .current_alpha (current_alpha),
        .current_beta  (current_beta),
        .volt_alpha    (volt_alpha),
        .volt_beta     (volt_beta),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .rotor_angle   (rotor_angle)
    );

    beo_angle_checker #(
        .SAMPLE_WIDTH (SAMPLE_W),
        .CORDIC_STEPS (STEPS)
    ) u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .current_alpha  (current_alpha),
        .current_beta   (current_beta),
        .volt_alpha     (volt_alpha),
        .volt_beta      (volt_beta),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .rotor_angle    (rotor_angle),
        .mismatch_count (mismatch_count),
        .angles_pending (angles_pending)
    );

    // clock
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // watchdog on cycles with no transaction at all
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // angle receiver: random back-pressure, one long hold on request
    initial
    begin
        out_ready = 1'b0;
        forever begin
            @(posedge clk);
            if (hold_req) begin
                hold_req = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end else begin
                out_ready <= calm || ($urandom_range(99) >= 18);
            end
        end
    end

    // mostly full-range values, some small ones and some extremes
    function automatic logic signed [SAMPLE_W-1:0] random_sample();
        case ($urandom_range(9))
            0:
                case ($urandom_range(4))
                    0:       return 16'sh7FFF;
                    1:       return 16'sh8000;
                    2:       return 16'sh0000;
                    3:       return -16'sd1;
                    default: return 16'sd1;
                endcase
            1, 2:    return SAMPLE_W'(int'($urandom_range(600)) - 300);
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    // one sample transaction, with an occasional gap after it
    task automatic send_sample(input logic signed [SAMPLE_W-1:0] ca,
                               input logic signed [SAMPLE_W-1:0] cb,
                               input logic signed [SAMPLE_W-1:0] va,
                               input logic signed [SAMPLE_W-1:0] vb);
        in_valid      <= 1'b1;
        current_alpha <= ca;
        current_beta  <= cb;
        volt_alpha    <= va;
        volt_beta     <= vb;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        if (!calm && $urandom_range(99) < 18) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    endtask

    task automatic send_random(input int count);
        repeat (count)
            send_sample(random_sample(), random_sample(), random_sample(), random_sample());
    endtask

    // stop offering and wait until every angle has come back
    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(posedge clk); while (angles_pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // setup and access cycle on the register port
    task automatic apb_access(input logic write, input logic idx,
                              input logic [APB_DATA_W-1:0] word);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write;
        paddr   <= {idx, 2'b00};
        pwdata  <= word;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // write both gains with junk above the field, then read them back
    task automatic set_gains(input logic [DECAY_W-1:0] kf, input logic [GAIN_W-1:0] kg);
        logic [APB_DATA_W-1:0] word;
        word = $urandom;
        word[DECAY_W-1:0] = kf;
        apb_access(1'b1, REG_DECAY_GAIN, word);
        apb_access(1'b0, REG_DECAY_GAIN, '0);
        word = $urandom;
        word[GAIN_W-1:0] = kg;
        apb_access(1'b1, REG_INPUT_GAIN, word);
        apb_access(1'b0, REG_INPUT_GAIN, '0);
    endtask

    // stimulus
    initial
    begin
        rst_n         = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        in_valid      = 1'b0;
        current_alpha = '0;
        current_beta  = '0;
        volt_alpha    = '0;
        volt_beta     = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset gains: back-EMF is minus the measured current
        send_sample(16'sd0, 16'sd0, 16'sd0, 16'sd0);
        send_sample(16'sd1, 16'sd0, 16'sh7FFF, 16'sh8000);
        send_sample(-16'sd1, 16'sd0, 16'sh8000, 16'sh7FFF);
        send_sample(16'sh8000, 16'sd0, 16'sd0, 16'sd0);
        send_sample(16'sh7FFF, 16'sd0, 16'sd0, 16'sd0);
        send_sample(16'sd0, 16'sh8000, 16'sd0, 16'sd0);
        send_sample(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
        send_sample(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
        send_sample(16'sd12345, -16'sd1, 16'sd0, 16'sd0);
        send_random(150);
        wait_drained();

        // largest gains, saturating predictions, no idling on either side
        set_gains(15'h7FFF, 16'hFFFF);
        calm = 1'b1;
        send_sample(16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh8000);
        send_sample(16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh7FFF);
        send_sample(16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000);
        send_sample(16'sd0, 16'sd0, 16'sd0, 16'sd0);
        send_sample(16'sd0, 16'sd0, 16'sd0, 16'sd0);
        send_sample(16'sd1, -16'sd1, -16'sd1, 16'sd1);
        send_random(300);
        wait_drained();
        calm = 1'b0;

        // receiver holds off while samples keep coming
        set_gains(15'd0, 16'hFFFF);
        hold_req = 1'b1;
        send_random(250);
        wait_drained();

        set_gains(15'h7FFF, 16'd0);
        send_random(250);
        wait_drained();

        // typical motor gains, with a drain pause midway
        set_gains(15'd29491, 16'd4096);
        send_random(200);
        wait_drained();
        send_random(200);
        wait_drained();

        set_gains(15'd0, 16'd0);
        send_random(150);
        wait_drained();

        set_gains(DECAY_W'($urandom), GAIN_W'($urandom));
        send_random(300);
        wait_drained();

        set_gains(15'd1, 16'd1);
        send_random(200);
        wait_drained();

        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
